// ===== rtl/core/swrp_pkg.sv =====
// Shared types and constants for the servo waypoint record and playback block.
package swrp_pkg;

  // Default number of stored waypoints
  localparam int unsigned WAYPOINTS_DEF = 64;

  // Number of servo axes and the home position after reset
  localparam int unsigned AXES     = 4;
  localparam logic [7:0]  HOME_DEG = 8'd90;

  // Axis indexes inside a waypoint word
  localparam logic [1:0] AX_BASE     = 2'd0;
  localparam logic [1:0] AX_SHOULDER = 2'd1;
  localparam logic [1:0] AX_ELBOW    = 2'd2;
  localparam logic [1:0] AX_GRIP     = 2'd3;

  // Command opcodes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_JOG    = 3'd1,
    OP_RECORD = 3'd2,
    OP_FILL   = 3'd3,
    OP_PLAY   = 3'd4
  } op_e;

  // Status codes returned with each result
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BUSY = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_STEP,
    S_FIN,
    S_FILL
  } seq_e;

endpackage

// ===== rtl/core/swrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swrp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = swrp_pkg::WAYPOINTS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/servo_waypoint_record_playback.sv =====
// Teach-and-playback controller for four servo axes with a waypoint store.
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i/in_stall_o    opcode_i, base_in_i .. grip_in_i
//  out      output     out_valid_o/out_stall_i  base_angle_o .. finished_o
//
// One command is processed at a time by a small sequencer around one shared
// axis stepper (compare and increment/decrement of one 8-bit position).
// Jog, record, play, ignored and idle-tick commands: the result is loaded from the execute state.
// Playback tick: store read plus one stepper pass per axis, over three axes in the
// first phase and over the grip axis alone in the grip phase.
// Fill: one store write per cycle, over all WAYPOINTS entries.
// Reset is asynchronous, active low; the input side stalls while it is held.
// The store needs no clearing pass since playback only reads entries below
// the record count.
// A pending result holds the input side stalled until it is taken.
module servo_waypoint_record_playback #(
  parameter int unsigned WAYPOINTS = swrp_pkg::WAYPOINTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] base_in_i,
  input  logic [7:0] shoulder_in_i,
  input  logic [7:0] elbow_in_i,
  input  logic [7:0] grip_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] base_angle_o,
  output logic [7:0] shoulder_angle_o,
  output logic [7:0] elbow_angle_o,
  output logic [7:0] grip_angle_o,
  output logic       playing_o,
  output logic       grip_phase_o,
  output logic [5:0] waypoint_now_o,
  output logic [6:0] recorded_o,
  output logic [1:0] status_o,
  output logic       finished_o
);

  localparam int unsigned IW = $clog2(WAYPOINTS);
  localparam int unsigned CW = $clog2(WAYPOINTS + 1);
  localparam int unsigned WW = 8 * swrp_pkg::AXES;

  // Sequencer and command registers
  swrp_pkg::seq_e    state_q, state_d;
  swrp_pkg::op_e     op_q, op_d;
  logic [WW-1:0]     vals_q, vals_d;

  // Block state
  logic [7:0]        pos_q [swrp_pkg::AXES];
  logic [7:0]        pos_d [swrp_pkg::AXES];
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     play_idx_q, play_idx_d;
  logic              active_q, active_d;
  logic              phase_q, phase_d;
  logic              restart_q, restart_d;

  // Working registers
  logic [1:0]        axis_q, axis_d;
  logic              all_eq_q, all_eq_d;
  logic [IW-1:0]     fill_idx_q, fill_idx_d;

  // Result registers
  logic              out_valid_q, out_valid_d;
  swrp_pkg::status_e status_q, status_d;
  logic              finished_q, finished_d;

  // Store interface
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic              ram_re;
  logic [WW-1:0]     ram_rdata;
  logic [7:0]        tgt_arr [swrp_pkg::AXES];

  // Decode and stepper signals
  logic              in_accept;
  logic              out_accept;
  logic              busy_cmd;
  logic              go_read;
  logic              go_fill;
  logic              last_axis;
  logic              fill_last;
  logic              load_out;
  logic [CW-1:0]     count_eff;
  logic              rec_full;
  logic              rec_write;
  logic              list_end;
  logic [7:0]        step_cur;
  logic [7:0]        step_tgt;
  logic [7:0]        step_nxt;
  logic              step_lt;
  logic              step_gt;
  logic              step_eq;
  logic [31:0]       idx_ext;
  logic [31:0]       cnt_ext;

  // Handshakes: take a command only out of reset, when idle and the result slot is free
  assign in_stall_o = !rst_ni ||
                      !((state_q == swrp_pkg::S_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Command decode
  assign busy_cmd = active_q && ((op_q == swrp_pkg::OP_JOG) || (op_q == swrp_pkg::OP_RECORD) ||
                                 (op_q == swrp_pkg::OP_FILL) || (op_q == swrp_pkg::OP_PLAY));
  assign go_read  = !busy_cmd && (op_q == swrp_pkg::OP_TICK) && active_q;
  assign go_fill  = !busy_cmd && (op_q == swrp_pkg::OP_FILL);
  assign last_axis = phase_q || (axis_q == swrp_pkg::AX_ELBOW);
  assign fill_last = (fill_idx_q == IW'(WAYPOINTS - 1));
  assign list_end  = ((CW'(play_idx_q) + CW'(1)) >= count_q);

  // Record bookkeeping: restart the list after a playback
  assign count_eff = restart_q ? '0 : count_q;
  assign rec_full  = (count_eff == CW'(WAYPOINTS));
  assign rec_write = (state_q == swrp_pkg::S_EXEC) && !busy_cmd &&
                     (op_q == swrp_pkg::OP_RECORD) && !rec_full;

  // Split the stored waypoint into axis targets
  for (genvar g = 0; g < swrp_pkg::AXES; g++) begin : g_tgt
    assign tgt_arr[g] = ram_rdata[8*g +: 8];
  end

  // Shared axis stepper
  assign step_cur = pos_q[axis_q];
  assign step_tgt = tgt_arr[axis_q];
  assign step_lt  = (step_cur < step_tgt);
  assign step_gt  = (step_cur > step_tgt);
  assign step_eq  = !step_lt && !step_gt;
  assign step_nxt = step_lt ? (step_cur + 8'd1) : (step_gt ? (step_cur - 8'd1) : step_cur);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swrp_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = swrp_pkg::S_EXEC;
        end
      end
      swrp_pkg::S_EXEC: begin
        if (go_read) begin
          state_d = swrp_pkg::S_READ;
        end else if (go_fill) begin
          state_d = swrp_pkg::S_FILL;
        end else begin
          state_d = swrp_pkg::S_IDLE;
        end
      end
      swrp_pkg::S_READ: state_d = swrp_pkg::S_STEP;
      swrp_pkg::S_STEP: begin
        if (last_axis) begin
          state_d = swrp_pkg::S_FIN;
        end
      end
      swrp_pkg::S_FIN:  state_d = swrp_pkg::S_IDLE;
      swrp_pkg::S_FILL: begin
        if (fill_last) begin
          state_d = swrp_pkg::S_IDLE;
        end
      end
      default: state_d = swrp_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: store access and result load
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_eff[IW-1:0];
    ram_re    = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      swrp_pkg::S_IDLE: ;
      swrp_pkg::S_EXEC: begin
        ram_we   = rec_write;
        load_out = !go_read && !go_fill;
      end
      swrp_pkg::S_READ: ram_re = 1'b1;
      swrp_pkg::S_STEP: ;
      swrp_pkg::S_FIN:  load_out = 1'b1;
      swrp_pkg::S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_idx_q;
        load_out  = fill_last;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    op_d       = op_q;
    vals_d     = vals_q;
    pos_d      = pos_q;
    count_d    = count_q;
    play_idx_d = play_idx_q;
    active_d   = active_q;
    phase_d    = phase_q;
    restart_d  = restart_q;
    axis_d     = axis_q;
    all_eq_d   = all_eq_q;
    fill_idx_d = fill_idx_q;
    status_d   = status_q;
    finished_d = finished_q;
    unique case (state_q)
      swrp_pkg::S_IDLE: begin
        // Latch the command
        if (in_accept) begin
          op_d       = swrp_pkg::op_e'(opcode_i);
          vals_d     = {grip_in_i, elbow_in_i, shoulder_in_i, base_in_i};
          status_d   = swrp_pkg::ST_OK;
          finished_d = 1'b0;
        end
      end
      swrp_pkg::S_EXEC: begin
        if (busy_cmd) begin
          status_d = swrp_pkg::ST_BUSY;
        end else begin
          case (op_q)
            swrp_pkg::OP_JOG: begin
              for (int k = 0; k < swrp_pkg::AXES; k++) begin
                pos_d[k] = vals_q[8*k +: 8];
              end
            end
            swrp_pkg::OP_RECORD: begin
              restart_d = 1'b0;
              count_d   = count_eff;
              if (rec_full) begin
                status_d = swrp_pkg::ST_FULL;
              end else begin
                count_d = count_eff + CW'(1);
              end
            end
            swrp_pkg::OP_FILL: fill_idx_d = '0;
            swrp_pkg::OP_PLAY: begin
              play_idx_d = '0;
              phase_d    = 1'b0;
              if (count_q == '0) begin
                restart_d  = 1'b1;
                finished_d = 1'b1;
              end else begin
                active_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      swrp_pkg::S_READ: begin
        axis_d   = phase_q ? swrp_pkg::AX_GRIP : swrp_pkg::AX_BASE;
        all_eq_d = 1'b1;
      end
      swrp_pkg::S_STEP: begin
        // Step one axis per cycle toward the waypoint
        pos_d[axis_q] = step_nxt;
        all_eq_d      = all_eq_q && step_eq;
        axis_d        = axis_q + 2'd1;
      end
      swrp_pkg::S_FIN: begin
        // Advance phase, waypoint or end the playback
        if (!phase_q) begin
          phase_d = all_eq_q;
        end else if (all_eq_q) begin
          phase_d = 1'b0;
          if (list_end) begin
            active_d   = 1'b0;
            restart_d  = 1'b1;
            finished_d = 1'b1;
          end else begin
            play_idx_d = play_idx_q + IW'(1);
          end
        end
      end
      swrp_pkg::S_FILL: fill_idx_d = fill_idx_q + IW'(1);
      default: ;
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_accept) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swrp_pkg::S_IDLE;
      for (int k = 0; k < swrp_pkg::AXES; k++) begin
        pos_q[k] <= swrp_pkg::HOME_DEG;
      end
      count_q     <= '0;
      play_idx_q  <= '0;
      active_q    <= 1'b0;
      phase_q     <= 1'b0;
      restart_q   <= 1'b0;
      axis_q      <= swrp_pkg::AX_BASE;
      all_eq_q    <= 1'b0;
      fill_idx_q  <= '0;
      out_valid_q <= 1'b0;
      status_q    <= swrp_pkg::ST_OK;
      finished_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      play_idx_q  <= play_idx_d;
      active_q    <= active_d;
      phase_q     <= phase_d;
      restart_q   <= restart_d;
      axis_q      <= axis_d;
      all_eq_q    <= all_eq_d;
      fill_idx_q  <= fill_idx_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      finished_q  <= finished_d;
    end
  end

  // Command payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    vals_q <= vals_d;
  end

  // Waypoint store
  swrp_ram #(
    .WIDTH (WW),
    .DEPTH (WAYPOINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (vals_q),
    .re_i    (ram_re),
    .raddr_i (play_idx_q),
    .rdata_o (ram_rdata)
  );

  // Result outputs
  assign idx_ext          = 32'(play_idx_q);
  assign cnt_ext          = 32'(count_q);
  assign out_valid_o      = out_valid_q;
  assign base_angle_o     = pos_q[swrp_pkg::AX_BASE];
  assign shoulder_angle_o = pos_q[swrp_pkg::AX_SHOULDER];
  assign elbow_angle_o    = pos_q[swrp_pkg::AX_ELBOW];
  assign grip_angle_o     = pos_q[swrp_pkg::AX_GRIP];
  assign playing_o        = active_q;
  assign grip_phase_o     = phase_q;
  assign waypoint_now_o   = idx_ext[5:0];
  assign recorded_o       = cnt_ext[6:0];
  assign status_o         = status_q;
  assign finished_o       = finished_q;

endmodule

// ===== rtl/core/swrp_checker.sv =====
// Port-level checks for the servo waypoint record and playback block.
module swrp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [2:0] opcode_i,
  input logic [7:0] base_in_i,
  input logic [7:0] shoulder_in_i,
  input logic [7:0] elbow_in_i,
  input logic [7:0] grip_in_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] base_angle_o,
  input logic [7:0] shoulder_angle_o,
  input logic [7:0] elbow_angle_o,
  input logic [7:0] grip_angle_o,
  input logic       playing_o,
  input logic       grip_phase_o,
  input logic [5:0] waypoint_now_o,
  input logic [6:0] recorded_o,
  input logic [1:0] status_o,
  input logic       finished_o
);

  // Block goes busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous transaction in progress");

  // A stalled command transaction stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(opcode_i) && $stable(base_in_i) && $stable(shoulder_in_i) &&
       $stable(elbow_in_i) && $stable(grip_in_i)))
    else $error("stalled command changed");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(base_angle_o) && $stable(shoulder_angle_o) &&
       $stable(elbow_angle_o) && $stable(grip_angle_o) && $stable(status_o) &&
       $stable(recorded_o) && $stable(waypoint_now_o) && $stable(playing_o) &&
       $stable(grip_phase_o) && $stable(finished_o)))
    else $error("stalled result changed");

  // A finished playback is no longer playing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> (!playing_o && !grip_phase_o))
    else $error("finished result still shows playback");

  // Grip phase exists only during playback
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !playing_o) |-> !grip_phase_o)
    else $error("grip phase outside playback");

endmodule

bind servo_waypoint_record_playback swrp_checker u_swrp_checker (.*);

// ===== tb/sv/servo_waypoint_record_playback_tb.sv =====
// Self-checking testbench for the servo waypoint record and playback controller.
module servo_waypoint_record_playback_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NWP = swrp_pkg::WAYPOINTS_DEF;

  // Opcodes outside the command set, ignored by the block
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Watchdog and drain limits, in clock cycles
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Expected pose and status after one command
  typedef struct packed {
    logic [7:0]        base;
    logic [7:0]        shoulder;
    logic [7:0]        elbow;
    logic [7:0]        grip;
    logic              playing;
    logic              grip_phase;
    logic [5:0]        waypoint_now;
    logic [6:0]        recorded;
    swrp_pkg::status_e status;
    logic              finished;
  } arm_pose_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [2:0] opcode_i         = swrp_pkg::OP_TICK;
  logic [7:0] base_in_i        = 8'd0;
  logic [7:0] shoulder_in_i    = 8'd0;
  logic [7:0] elbow_in_i       = 8'd0;
  logic [7:0] grip_in_i        = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [7:0] base_angle_o;
  logic [7:0] shoulder_angle_o;
  logic [7:0] elbow_angle_o;
  logic [7:0] grip_angle_o;
  logic       playing_o;
  logic       grip_phase_o;
  logic [5:0] waypoint_now_o;
  logic [6:0] recorded_o;
  logic [1:0] status_o;
  logic       finished_o;

  // Arm state as the testbench expects it
  logic [7:0]  axis_m  [swrp_pkg::AXES];
  logic [7:0]  store_m [NWP][swrp_pkg::AXES];
  int unsigned count_m;
  int unsigned idx_m;
  bit          playing_m;
  bit          phase_m;
  bit          restart_m;

  arm_pose_t   pending_poses[$];
  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  int unsigned quiet_from  = 32'hFFFF_FFFF;
  bit          pace_on = 1'b1;

  servo_waypoint_record_playback dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .base_in_i        (base_in_i),
    .shoulder_in_i    (shoulder_in_i),
    .elbow_in_i       (elbow_in_i),
    .grip_in_i        (grip_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .base_angle_o     (base_angle_o),
    .shoulder_angle_o (shoulder_angle_o),
    .elbow_angle_o    (elbow_angle_o),
    .grip_angle_o     (grip_angle_o),
    .playing_o        (playing_o),
    .grip_phase_o     (grip_phase_o),
    .waypoint_now_o   (waypoint_now_o),
    .recorded_o       (recorded_o),
    .status_o         (status_o),
    .finished_o       (finished_o)
  );

  always #2ns clk_i = ~clk_i;

  // Step one expected axis one degree toward target; return 1 if already there
  function automatic bit step_axis(input logic [1:0] ax, input logic [7:0] target);
    if (axis_m[ax] < target) begin
      axis_m[ax] = axis_m[ax] + 8'd1;
      return 1'b0;
    end
    if (axis_m[ax] > target) begin
      axis_m[ax] = axis_m[ax] - 8'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one command to the expected arm state and return the resulting pose
  function automatic arm_pose_t predict_arm_pose(input logic [2:0] op, input logic [7:0] b,
                                                 input logic [7:0] s, input logic [7:0] e,
                                                 input logic [7:0] g);
    arm_pose_t         r;
    swrp_pkg::status_e st;
    logic              done;
    bit                at_b, at_s, at_e;
    st   = swrp_pkg::ST_OK;
    done = 1'b0;
    if (op == swrp_pkg::OP_TICK) begin
      if (playing_m) begin
        if (!phase_m) begin
          at_b = step_axis(swrp_pkg::AX_BASE, store_m[idx_m][swrp_pkg::AX_BASE]);
          at_s = step_axis(swrp_pkg::AX_SHOULDER, store_m[idx_m][swrp_pkg::AX_SHOULDER]);
          at_e = step_axis(swrp_pkg::AX_ELBOW, store_m[idx_m][swrp_pkg::AX_ELBOW]);
          if (at_b && at_s && at_e) phase_m = 1'b1;
        end else if (step_axis(swrp_pkg::AX_GRIP, store_m[idx_m][swrp_pkg::AX_GRIP])) begin
          // grip arrived: advance to the next waypoint or end playback
          phase_m = 1'b0;
          if (idx_m + 1 >= count_m) begin
            playing_m = 1'b0;
            restart_m = 1'b1;
            done      = 1'b1;
          end else begin
            idx_m++;
          end
        end
      end
    end else if (op <= swrp_pkg::OP_PLAY && playing_m) begin
      st = swrp_pkg::ST_BUSY;
    end else if (op == swrp_pkg::OP_JOG) begin
      axis_m[swrp_pkg::AX_BASE]     = b;
      axis_m[swrp_pkg::AX_SHOULDER] = s;
      axis_m[swrp_pkg::AX_ELBOW]    = e;
      axis_m[swrp_pkg::AX_GRIP]     = g;
    end else if (op == swrp_pkg::OP_RECORD) begin
      if (restart_m) begin
        count_m   = 0;
        restart_m = 1'b0;
      end
      if (count_m >= NWP) begin
        st = swrp_pkg::ST_FULL;
      end else begin
        store_m[count_m][swrp_pkg::AX_BASE]     = b;
        store_m[count_m][swrp_pkg::AX_SHOULDER] = s;
        store_m[count_m][swrp_pkg::AX_ELBOW]    = e;
        store_m[count_m][swrp_pkg::AX_GRIP]     = g;
        count_m++;
      end
    end else if (op == swrp_pkg::OP_FILL) begin
      for (int w = 0; w < NWP; w++) begin
        store_m[w][swrp_pkg::AX_BASE]     = b;
        store_m[w][swrp_pkg::AX_SHOULDER] = s;
        store_m[w][swrp_pkg::AX_ELBOW]    = e;
        store_m[w][swrp_pkg::AX_GRIP]     = g;
      end
    end else if (op == swrp_pkg::OP_PLAY) begin
      idx_m   = 0;
      phase_m = 1'b0;
      if (count_m == 0) begin
        restart_m = 1'b1;
        done      = 1'b1;
      end else begin
        playing_m = 1'b1;
      end
    end
    r.base         = axis_m[swrp_pkg::AX_BASE];
    r.shoulder     = axis_m[swrp_pkg::AX_SHOULDER];
    r.elbow        = axis_m[swrp_pkg::AX_ELBOW];
    r.grip         = axis_m[swrp_pkg::AX_GRIP];
    r.playing      = playing_m;
    r.grip_phase   = phase_m;
    r.waypoint_now = idx_m[5:0];
    r.recorded     = count_m[6:0];
    r.status       = st;
    r.finished     = done;
    return r;
  endfunction

  // Pick a position a few degrees from a given one, now and then anywhere
  function automatic logic [7:0] near_deg(input logic [7:0] from);
    int v;
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    v = int'($urandom_range(0, 12)) - 6 + int'(from);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Send one command transaction, then record its expected pose
  task automatic send_cmd(input logic [2:0] op, input logic [7:0] b, input logic [7:0] s,
                          input logic [7:0] e, input logic [7:0] g);
    arm_pose_t want;
    // no idling on either side in the last stretch
    if (items_sent >= quiet_from) pace_on = 1'b0;
    if (pace_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    base_in_i     <= b;
    shoulder_in_i <= s;
    elbow_in_i    <= e;
    grip_in_i     <= g;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    want = predict_arm_pose(op, b, s, e, g);
    pending_poses.push_back(want);
    items_sent++;
  endtask

  // Tick until the playback ends, slipping in refused or ignored commands now and then
  task automatic play_to_end();
    while (playing_m) begin
      if ($urandom_range(0, 7) == 0)
        send_cmd(3'($urandom_range(swrp_pkg::OP_JOG, OP_SPARE_HI)), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_cmd(swrp_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    end
  endtask

  // Idle commands, extremes, empty playback, restart, busy refusals, a short playback
  task automatic test_directed_commands();
    send_cmd(swrp_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(OP_SPARE_HI, 8'd255, 8'd255, 8'd255, 8'd255);
    send_cmd(OP_SPARE_LO, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(swrp_pkg::OP_JOG, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(swrp_pkg::OP_JOG, 8'd255, 8'd255, 8'd255, 8'd255);
    send_cmd(swrp_pkg::OP_JOG, 8'd10, 8'd20, 8'd30, 8'd40);
    send_cmd(swrp_pkg::OP_PLAY, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(swrp_pkg::OP_RECORD, 8'd12, 8'd21, 8'd30, 8'd41);
    send_cmd(swrp_pkg::OP_RECORD, 8'd12, 8'd21, 8'd30, 8'd41);
    send_cmd(swrp_pkg::OP_RECORD, 8'd10, 8'd20, 8'd30, 8'd40);
    send_cmd(swrp_pkg::OP_PLAY, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(swrp_pkg::OP_JOG, 8'd1, 8'd2, 8'd3, 8'd4);
    send_cmd(swrp_pkg::OP_RECORD, 8'd1, 8'd2, 8'd3, 8'd4);
    send_cmd(swrp_pkg::OP_FILL, 8'd1, 8'd2, 8'd3, 8'd4);
    send_cmd(swrp_pkg::OP_PLAY, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(OP_SPARE_HI, 8'd0, 8'd0, 8'd0, 8'd0);
    play_to_end();
  endtask

  // Fill over a short list, then fill a full list and play all of it back
  task automatic test_fill_and_full_list();
    send_cmd(swrp_pkg::OP_FILL, axis_m[swrp_pkg::AX_BASE] + 8'd3,
             axis_m[swrp_pkg::AX_SHOULDER] - 8'd2, axis_m[swrp_pkg::AX_ELBOW],
             axis_m[swrp_pkg::AX_GRIP] + 8'd1);
    send_cmd(swrp_pkg::OP_PLAY, 8'd0, 8'd0, 8'd0, 8'd0);
    play_to_end();
    for (int k = 0; k < NWP; k++)
      send_cmd(swrp_pkg::OP_RECORD, 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
    send_cmd(swrp_pkg::OP_RECORD, 8'd255, 8'd0, 8'd255, 8'd0);
    send_cmd(swrp_pkg::OP_RECORD, 8'd0, 8'd255, 8'd0, 8'd255);
    send_cmd(swrp_pkg::OP_FILL, near_deg(axis_m[swrp_pkg::AX_BASE]),
             near_deg(axis_m[swrp_pkg::AX_SHOULDER]), near_deg(axis_m[swrp_pkg::AX_ELBOW]),
             near_deg(axis_m[swrp_pkg::AX_GRIP]));
    send_cmd(swrp_pkg::OP_PLAY, 8'd0, 8'd0, 8'd0, 8'd0);
    play_to_end();
  endtask

  // Mostly record-and-play sessions with nearby waypoints, plus jogs, fills and noise
  task automatic test_random_sessions(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned quiet_at;
    int unsigned n_rec;
    logic [7:0]  wb, ws, we, wg;
    stop_at    = items_sent + n_items;
    quiet_at   = stop_at - 100;
    quiet_from = quiet_at;
    while (items_sent < stop_at) begin
      // no idling on either side in the last stretch
      pace_on = (items_sent < quiet_at) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          send_cmd(swrp_pkg::OP_JOG, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
        end
        1: begin
          send_cmd(swrp_pkg::OP_FILL, near_deg(axis_m[swrp_pkg::AX_BASE]),
                   near_deg(axis_m[swrp_pkg::AX_SHOULDER]),
                   near_deg(axis_m[swrp_pkg::AX_ELBOW]),
                   near_deg(axis_m[swrp_pkg::AX_GRIP]));
        end
        2: begin
          if ($urandom_range(0, 1) == 0)
            send_cmd(swrp_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
          else
            send_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
        end
        default: begin
          n_rec = $urandom_range(1, 8);
          wb = axis_m[swrp_pkg::AX_BASE];
          ws = axis_m[swrp_pkg::AX_SHOULDER];
          we = axis_m[swrp_pkg::AX_ELBOW];
          wg = axis_m[swrp_pkg::AX_GRIP];
          for (int k = 0; k < n_rec; k++) begin
            wb = near_deg(wb);
            ws = near_deg(ws);
            we = near_deg(we);
            wg = near_deg(wg);
            send_cmd(swrp_pkg::OP_RECORD, wb, ws, we, wg);
          end
          // now and then keep appending instead of playing back
          if ($urandom_range(0, 4) != 0) begin
            send_cmd(swrp_pkg::OP_PLAY, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
            play_to_end();
          end
        end
      endcase
    end
  endtask

  // Report one field mismatch
  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Check each result transaction against the oldest expected pose
  always @(posedge clk_i) begin
    arm_pose_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_poses.size() == 0) begin
        $error("result transaction with no command outstanding");
        mismatches++;
      end else begin
        want = pending_poses.pop_front();
        compare_field("base_angle", want.base, base_angle_o);
        compare_field("shoulder_angle", want.shoulder, shoulder_angle_o);
        compare_field("elbow_angle", want.elbow, elbow_angle_o);
        compare_field("grip_angle", want.grip, grip_angle_o);
        compare_field("playing", 8'(want.playing), 8'(playing_o));
        compare_field("grip_phase", 8'(want.grip_phase), 8'(grip_phase_o));
        compare_field("waypoint_now", 8'(want.waypoint_now), 8'(waypoint_now_o));
        compare_field("recorded", 8'(want.recorded), 8'(recorded_o));
        compare_field("status", 8'(want.status), 8'(status_o));
        compare_field("finished", 8'(want.finished), 8'(finished_o));
      end
    end
  end

  // Stall the result side in random bursts while pacing is on
  always @(posedge clk_i) begin
    if (!rst_ni || !pace_on) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 13);
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(1, 20);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // End the run if no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // expected state matches the block after reset
    for (int w = 0; w < NWP; w++)
      for (int a = 0; a < swrp_pkg::AXES; a++) store_m[w][a] = swrp_pkg::HOME_DEG;
    for (int a = 0; a < swrp_pkg::AXES; a++) axis_m[a] = swrp_pkg::HOME_DEG;
    count_m     = 0;
    idx_m       = 0;
    playing_m   = 1'b0;
    phase_m     = 1'b0;
    restart_m   = 1'b0;
    items_sent  = 0;
    mismatches  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_commands();
    test_fill_and_full_list();
    test_random_sessions(480);

    // drain outstanding results, then watch for strays
    in_valid_i <= 1'b0;
    pace_on = 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_poses.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== servo_waypoint_record_playback.f =====
rtl/core/swrp_pkg.sv
rtl/core/swrp_ram.sv
rtl/core/servo_waypoint_record_playback.sv
rtl/core/swrp_checker.sv
tb/sv/servo_waypoint_record_playback_tb.sv
